FILE: design/sali_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sali_pkg
// Shared types and constants of the sparse anchor line interpolator.
// ----------------------------------------------------------------------------
package sali_pkg;

    localparam int VAL_W = 12;  // anchor / mapped coordinate width
    localparam int POS_W = 11;  // position and line length width

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_LINE_LENGTH = 1'b0;
    localparam logic CFG_END_VALUE   = 1'b1;

    localparam logic [POS_W-1:0] LEN_RESET    = 11'd1024;
    localparam logic [VAL_W-1:0] END_RESET    = 12'd1024;
    localparam logic [VAL_W-1:0] LEFT_DEFAULT = 12'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CTR_RD,
        ST_CTR_CHK,
        ST_LEFT,
        ST_RIGHT,
        ST_LAUNCH,
        ST_WAIT
    } t_state;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL_A,
        AR_MUL_B,
        AR_DIV,
        AR_ROUND
    } t_arith_state;

endpackage
`default_nettype wire

FILE: design/sparse_anchor_line_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_anchor_line_interpolator
// One line of sparse anchor coordinates with piecewise linear lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present opcode/position/anchor_value with start high; the
//   beat is taken at an edge where busy is low. Each beat yields one result
//   beat on o_result_valid, high for exactly one cycle; the receiver cannot
//   stall and must take it then.
//   Config channel: i_cfg_valid/o_cfg_ready (always ready) with i_cfg_index
//   (0 = line_length, 1 = end_value) and i_cfg_data. Write only while idle.
//   Sequence: a write shows its result in the cycle after accept and busy
//   stays low, so writes stream one per cycle. A query on an anchored
//   position reads the RAM (ST_CTR_RD), checks the entry (ST_CTR_CHK) and
//   answers from the result register. Otherwise the anchor RAM is scanned one
//   entry per cycle to the left and then to the right of the position,
//   followed by the arithmetic unit: a multiply step per anchor, the
//   restoring divide and a rounding step. The result beat of a query comes
//   out in the same cycle busy drops.
//   Reset: synchronous, active low. Registers take their reset values and a
//   clearing pass writes zero to all LINE_MAX RAM entries, one per cycle;
//   busy stays high throughout the pass. Config writes are taken.
// ----------------------------------------------------------------------------
module sparse_anchor_line_interpolator
    import sali_pkg::*;
#(
    parameter int LINE_MAX = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // command channel
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             i_opcode,
    input  wire logic [POS_W-1:0] i_position,
    input  wire logic [VAL_W-1:0] i_anchor_value,
    // configuration channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [VAL_W-1:0] i_cfg_data,
    // result channel
    output logic                  o_result_valid,
    output logic      [VAL_W-1:0] o_mapped,
    output logic                  o_from_anchor
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int DW = $clog2(LINE_MAX + 1);          // holds 0..LINE_MAX
    localparam int LW = (DW > POS_W) ? DW : POS_W;     // compare width

    // configuration registers
    logic [POS_W-1:0] r_line_length;
    logic [VAL_W-1:0] r_end_value;

    // sequencer
    t_state r_state, n_state;
    logic [DW-1:0]    r_k, n_k;       // next position to read
    logic [DW-1:0]    r_kd, n_kd;     // position whose data is on rd_data
    logic             r_dv, n_dv;     // rd_data belongs to a scan read
    logic [DW-1:0]    r_pos, n_pos;   // clamped query position
    logic [DW-1:0]    r_len, n_len;   // effective line length
    logic [VAL_W-1:0] r_a1, n_a1;
    logic [VAL_W-1:0] r_a2, n_a2;
    logic [DW-1:0]    r_d1, n_d1;
    logic [DW-1:0]    r_d2, n_d2;
    logic             n_result_valid;
    logic [VAL_W-1:0] n_mapped;
    logic             n_from_anchor;

    // RAM ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] rd_data;

    // arithmetic unit
    logic             arith_start;
    logic             arith_done;
    logic [VAL_W-1:0] arith_quot;

    logic          accept;
    logic          wr_in_range;
    logic [LW-1:0] len_ext;
    logic [LW-1:0] eff_len;
    logic [LW-1:0] pos_ext;
    logic [LW-1:0] pos_clamp;
    logic          rd_hit;
    logic          left_done;
    logic          right_done;
    logic          clear_last;

    assign accept = start && !busy;

    // clamp line length to 2..LINE_MAX and query position to 1..L
    assign len_ext   = LW'(r_line_length);
    assign eff_len   = (len_ext < LW'(2))        ? LW'(2)
                     : (len_ext > LW'(LINE_MAX)) ? LW'(LINE_MAX) : len_ext;
    assign pos_ext   = LW'(i_position);
    assign pos_clamp = (pos_ext == '0)    ? LW'(1)
                     : (pos_ext > eff_len) ? eff_len : pos_ext;

    // drop writes at position zero or past the end of the store
    assign wr_in_range = (pos_ext != '0) && (pos_ext <= LW'(LINE_MAX));

    assign rd_hit     = rd_data != '0;
    assign left_done  = r_dv && (rd_hit || (r_kd == DW'(1)));
    assign right_done = r_dv && (rd_hit || (r_kd == r_len));
    assign clear_last = r_k == DW'(LINE_MAX - 1);

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            r_end_value   <= END_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[POS_W-1:0];
                CFG_END_VALUE:   r_end_value   <= i_cfg_data;
                default:         r_line_length <= r_line_length;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (clear_last) n_state = ST_IDLE;
            ST_IDLE:    if (accept && (i_opcode == OP_QUERY)) n_state = ST_CTR_RD;
            ST_CTR_RD:  n_state = ST_CTR_CHK;
            ST_CTR_CHK: begin
                if (rd_hit) begin
                    n_state = ST_IDLE;
                end else if (r_pos != DW'(1)) begin
                    n_state = ST_LEFT;
                end else begin
                    n_state = ST_RIGHT;
                end
            end
            ST_LEFT: begin
                if (left_done) begin
                    n_state = (r_pos == r_len) ? ST_LAUNCH : ST_RIGHT;
                end
            end
            ST_RIGHT:   if (right_done) n_state = ST_LAUNCH;
            ST_LAUNCH:  n_state = ST_WAIT;
            ST_WAIT:    if (arith_done) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: RAM ports, handshake, arithmetic kick
    always_comb begin
        busy        = r_state != ST_IDLE;
        arith_start = r_state == ST_LAUNCH;
        ram_raddr   = AW'(r_k - DW'(1));
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_k);
        ram_wdata   = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                ram_we    = accept && (i_opcode == OP_WRITE) && wr_in_range;
                ram_waddr = AW'(pos_ext - LW'(1));
                ram_wdata = i_anchor_value;
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        n_k            = r_k;
        n_kd           = r_kd;
        n_dv           = r_dv;
        n_pos          = r_pos;
        n_len          = r_len;
        n_a1           = r_a1;
        n_a2           = r_a2;
        n_d1           = r_d1;
        n_d2           = r_d2;
        n_result_valid = 1'b0;
        n_mapped       = '0;
        n_from_anchor  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_k = r_k + DW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_WRITE) begin
                        n_result_valid = 1'b1;
                    end else begin
                        n_k   = DW'(pos_clamp);
                        n_pos = DW'(pos_clamp);
                        n_len = DW'(eff_len);
                    end
                end
            end
            ST_CTR_CHK: begin
                if (rd_hit) begin
                    n_result_valid = 1'b1;
                    n_mapped       = rd_data;
                    n_from_anchor  = 1'b1;
                end else begin
                    // load the line-end defaults, scans overwrite on a hit
                    n_a1 = LEFT_DEFAULT;
                    n_d1 = r_pos - DW'(1);
                    n_a2 = r_end_value;
                    n_d2 = r_len - r_pos;
                    n_dv = 1'b0;
                    n_k  = (r_pos == DW'(1)) ? r_pos + DW'(1) : r_pos - DW'(1);
                end
            end
            ST_LEFT: begin
                if (left_done) begin
                    if (rd_hit) begin
                        n_a1 = rd_data;
                        n_d1 = r_pos - r_kd;
                    end
                    n_dv = 1'b0;
                    n_k  = r_pos + DW'(1);
                end else begin
                    n_kd = r_k;
                    n_dv = 1'b1;
                    n_k  = r_k - DW'(1);
                end
            end
            ST_RIGHT: begin
                if (right_done) begin
                    if (rd_hit) begin
                        n_a2 = rd_data;
                        n_d2 = r_kd - r_pos;
                    end
                    n_dv = 1'b0;
                end else begin
                    n_kd = r_k;
                    n_dv = 1'b1;
                    n_k  = r_k + DW'(1);
                end
            end
            ST_WAIT: begin
                if (arith_done) begin
                    n_result_valid = 1'b1;
                    n_mapped       = arith_quot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_k            <= '0;
            r_dv           <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_k            <= n_k;
            r_dv           <= n_dv;
            o_result_valid <= n_result_valid;
        end
        r_kd          <= n_kd;
        r_pos         <= n_pos;
        r_len         <= n_len;
        r_a1          <= n_a1;
        r_a2          <= n_a2;
        r_d1          <= n_d1;
        r_d2          <= n_d2;
        o_mapped      <= n_mapped;
        o_from_anchor <= n_from_anchor;
    end

    sali_ram #(
        .WIDTH (VAL_W),
        .DEPTH (LINE_MAX)
    ) u_anchor_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    sali_arith #(
        .DW (DW)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (arith_start),
        .i_a1    (r_a1),
        .i_a2    (r_a2),
        .i_d1    (r_d1),
        .i_d2    (r_d2),
        .o_done  (arith_done),
        .o_quot  (arith_quot)
    );

endmodule
`default_nettype wire

FILE: design/sali_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sali_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sali_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: design/sali_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sali_arith
// Weighted sum of two anchors, then restoring division one bit per cycle
// with round-half-to-even on the quotient.
// ----------------------------------------------------------------------------
module sali_arith
    import sali_pkg::*;
#(
    parameter int DW = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [VAL_W-1:0] i_a1,
    input  wire logic [VAL_W-1:0] i_a2,
    input  wire logic [DW-1:0]    i_d1,
    input  wire logic [DW-1:0]    i_d2,
    output logic                  o_done,
    output logic      [VAL_W-1:0] o_quot
);

    localparam int NW = VAL_W + DW + 1;
    localparam int CW = $clog2(NW + 1);

    t_arith_state r_state, n_state;
    logic [NW-1:0]  r_num, n_num;
    logic [DW-1:0]  r_rem, n_rem;
    logic [DW-1:0]  r_den, n_den;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           n_done;
    logic [VAL_W-1:0] n_quot;

    logic [DW:0]    trial;
    logic           fits;
    logic [DW:0]    twice_rem;
    logic           round_up;

    assign trial     = {r_rem, r_num[NW-1]};
    assign fits      = trial >= {1'b0, r_den};
    assign twice_rem = {r_rem, 1'b0};
    assign round_up  = (twice_rem > {1'b0, r_den})
                    || ((twice_rem == {1'b0, r_den}) && r_num[0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            AR_IDLE:  if (i_start) n_state = AR_MUL_A;
            AR_MUL_A: n_state = AR_MUL_B;
            AR_MUL_B: n_state = AR_DIV;
            AR_DIV:   if (r_cnt == CW'(1)) n_state = AR_ROUND;
            AR_ROUND: n_state = AR_IDLE;
            default:  n_state = AR_IDLE;
        endcase
    end

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quot = o_quot;
        case (r_state)
            AR_MUL_A: begin
                n_num = NW'(i_a1) * NW'(i_d2);
            end
            AR_MUL_B: begin
                n_num = r_num + NW'(i_a2) * NW'(i_d1);
                n_den = DW'({1'b0, i_d1} + {1'b0, i_d2});
                n_rem = '0;
                n_cnt = CW'(NW);
            end
            AR_DIV: begin
                // shift the next dividend bit in, subtract when it fits
                n_rem = fits ? DW'(trial - {1'b0, r_den}) : DW'(trial);
                n_num = {r_num[NW-2:0], fits};
                n_cnt = r_cnt - CW'(1);
            end
            AR_ROUND: begin
                n_done = 1'b1;
                n_quot = r_num[VAL_W-1:0] + VAL_W'(round_up);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AR_IDLE;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= n_done;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_cnt  <= n_cnt;
        o_quot <= n_quot;
    end

endmodule
`default_nettype wire

FILE: design/sali_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sali_checker
// Port-level checks of the sparse anchor line interpolator.
// ----------------------------------------------------------------------------
module sali_checker
    import sali_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             i_opcode,
    input wire logic             o_result_valid,
    input wire logic [VAL_W-1:0] o_mapped,
    input wire logic             o_from_anchor
);

    // reset starts the clearing pass and drops the result strobe
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_result_valid)
        else $error("reset did not start clearing pass");

    // a write beat answers in the next cycle with a zero result
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_WRITE)
        |=> o_result_valid && (o_mapped == '0) && !o_from_anchor)
        else $error("write beat not answered in one cycle");

    // a query beat holds the block busy and gives no immediate result
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_QUERY) |=> busy && !o_result_valid)
        else $error("query did not hold busy");

    // an anchored answer is a real result with a nonzero value
    a_anchor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_from_anchor |-> o_result_valid && (o_mapped != '0))
        else $error("anchor flag without a nonzero result");

    // a query result releases busy in the same cycle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !$past(start && !busy) |-> !busy)
        else $error("query result while still busy");

endmodule

bind sparse_anchor_line_interpolator sali_checker u_sali_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_opcode       (i_opcode),
    .o_result_valid (o_result_valid),
    .o_mapped       (o_mapped),
    .o_from_anchor  (o_from_anchor)
);
`default_nettype wire
